// ===== design/fqd_pkg.sv =====
// Package for the FIFO queue with delete by value.
// Holds sizes, operation and status codes, and the cell control struct.
// No dependencies.
package fqd_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef logic [DATA_WIDTH-1:0] entry_t;
	typedef logic [CNT_W-1:0]      count_t;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_DELETE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Operation broadcast to every cell for the word being accepted.
	typedef struct packed {
		logic   push;
		logic   pop;
		logic   del;
		entry_t key;
	} cell_ctl_t;

endpackage

// ===== design/fqd_cell.sv =====
// One storage cell of the queue: holds one entry, compares it to the key,
// and shifts in its upper neighbor's entry when the queue closes a gap.
// Depends on fqd_pkg.
module fqd_cell
	import fqd_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  logic      load,
	input  entry_t    next_entry,
	input  logic      hit_in,
	input  entry_t    rem_in,
	output entry_t    entry,
	output logic      hit_out,
	output entry_t    rem_out
);

	entry_t entry_q;
	logic   match;
	logic   first;

	assign match   = ctl.del && occupied && (entry_q == ctl.key);
	assign hit_out = hit_in | match;
	assign first   = match & ~hit_in;
	assign rem_out = first ? entry_q : rem_in;
	assign entry   = entry_q;

	// Push loads the key; pop, or delete from the first match up, shifts in.
	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= ctl.key;
		end else if (ctl.pop || (ctl.del && hit_out)) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ===== design/fifo_queue_with_delete_by_value_unit.sv =====
// Top level of the FIFO queue with delete by value: a row of fqd_cell cells
// plus the entry count and the registered result. Depends on fqd_pkg, fqd_cell.
//
// The queue takes one word per cycle: busy is always low, and the result of a
// word accepted at one edge is registered and is on the result ports, with
// done high, in the cycle after that edge. This is possible because the row
// of cells compares every entry against the key in parallel and shifts the
// entries above a removed one down by one cell in the same cycle. The receiver
// cannot stall, so results must be taken on the cycle that done is high.
module fifo_queue_with_delete_by_value_unit
	import fqd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic signed [31:0] data_value,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] removed_value,
	output logic [4:0]         fill_count
);

	count_t    count_q;
	count_t    count_d;
	logic      accept;
	cell_ctl_t ctl;
	status_t   status_d;
	entry_t    removed_d;
	logic      done_q;
	status_t   status_q;
	entry_t    removed_q;
	logic      full;
	logic      empty;
	logic      found;
	logic [63:0] key_wide;
	logic [63:0] rem_wide;

	entry_t ent [DEPTH];
	logic   hit [DEPTH+1];
	entry_t rem [DEPTH+1];

	assign busy     = 1'b0;
	assign accept   = start & ~busy;
	assign full     = (count_q == count_t'(DEPTH));
	assign empty    = (count_q == '0);
	assign key_wide = 64'($unsigned(data_value));
	assign hit[0]   = 1'b0;
	assign rem[0]   = '0;
	assign found    = hit[DEPTH];

	// The cell controls are decoded apart from the result so that the match
	// chain never feeds back into the block that drives it.
	always_comb begin
		ctl.key  = key_wide[DATA_WIDTH-1:0];
		ctl.push = 1'b0;
		ctl.pop  = 1'b0;
		ctl.del  = 1'b0;
		unique case (mode_t'(mode))
			MODE_PUSH: begin
				ctl.push = accept & ~full;
			end
			MODE_POP: begin
				ctl.pop = accept & ~empty;
			end
			MODE_DELETE: begin
				ctl.del = accept;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		status_d  = ST_OK;
		removed_d = '0;
		count_d   = count_q;
		unique case (mode_t'(mode))
			MODE_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d  = count_q + count_t'(1);
				end
			end
			MODE_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					removed_d = ent[0];
					count_d   = count_q - count_t'(1);
				end
			end
			MODE_DELETE: begin
				if (found) begin
					removed_d = rem[DEPTH];
					count_d   = count_q - count_t'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t nbr;
		if (i == DEPTH - 1) begin : g_last
			assign nbr = ent[i];
		end else begin : g_mid
			assign nbr = ent[i+1];
		end

		fqd_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (count_q > count_t'(i)),
			.load       (ctl.push && (count_q == count_t'(i))),
			.next_entry (nbr),
			.hit_in     (hit[i]),
			.rem_in     (rem[i]),
			.entry      (ent[i]),
			.hit_out    (hit[i+1]),
			.rem_out    (rem[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_d;
			removed_q <= removed_d;
		end
	end

	assign rem_wide      = 64'(removed_q);
	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = rem_wide[31:0];
	assign fill_count    = 5'(count_q);

endmodule
